// ----- sv/bba_pkg.sv -----
// Shared types and constants for the block bitmap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bba_pkg;

  // Request codes carried on req_type
  typedef enum logic [1:0] {
    REQ_QUERY     = 2'd0,
    REQ_FIND      = 2'd1,
    REQ_MARK_USED = 2'd2,
    REQ_MARK_FREE = 2'd3
  } req_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OP_RD,
    ST_OP_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK
  } state_e;

  // Map word geometry: eight bytes per memory word
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned WORD_BITS   = WORD_BYTES * 8;
  // Words reachable by a 15-bit block number (4096 bytes)
  localparam int unsigned IDX_WORDS   = 512;
  // Limit arithmetic width, wide enough for any map size
  localparam int unsigned LIM_W       = 17;
  localparam logic [7:0]  FULL_BYTE   = 8'hFF;
  localparam logic [3:0]  MAP_SECT_RST = 4'd7;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch request, rewind scan pointer
    logic clr_step;    // zero one word of the map, advance clear pointer
    logic op_read;     // read the word holding the latched block
    logic op_finish;   // produce query/mark result, write back a mark
    logic scan_read;   // read the word at the scan pointer
    logic scan_next;   // advance the scan pointer
    logic find_done;   // produce the find result
    logic find_hit;    // find result reports a free block
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;    // clear pointer on the last word
    logic start_find;  // request on the input ports is a find
    logic idx_err;     // latched block lies beyond the map in use
    logic scan_in_rng; // scan pointer below the map in use
    logic scan_hit;    // read word holds a byte with a free bit
  } dp_status_t;

endpackage

// ----- sv/bba_ctrl.sv -----
// Controller state machine for the block bitmap allocator.
// Depends on bba_pkg; drives the datapath through ctrl_cmd_t only.
module bba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bba_pkg::dp_status_t status_i,
  output bba_pkg::ctrl_cmd_t  cmd_o
);

  bba_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bba_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_IDLE: begin
        if (start) begin
          state_d = status_i.start_find ? bba_pkg::ST_SCAN_RD : bba_pkg::ST_OP_RD;
        end
      end
      bba_pkg::ST_OP_RD: begin
        state_d = status_i.idx_err ? bba_pkg::ST_IDLE : bba_pkg::ST_OP_WR;
      end
      bba_pkg::ST_OP_WR: begin
        state_d = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_SCAN_RD: begin
        state_d = status_i.scan_in_rng ? bba_pkg::ST_SCAN_CHK : bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_SCAN_CHK: begin
        state_d = status_i.scan_hit ? bba_pkg::ST_IDLE : bba_pkg::ST_SCAN_RD;
      end
      default: begin
        state_d = bba_pkg::ST_CLEAR;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      bba_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      bba_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      bba_pkg::ST_OP_RD: begin
        // out-of-range index finishes at once with the error flag
        cmd_o.op_read   = !status_i.idx_err;
        cmd_o.op_finish = status_i.idx_err;
      end
      bba_pkg::ST_OP_WR: begin
        cmd_o.op_finish = 1'b1;
      end
      bba_pkg::ST_SCAN_RD: begin
        cmd_o.scan_read = status_i.scan_in_rng;
        cmd_o.find_done = !status_i.scan_in_rng;
      end
      bba_pkg::ST_SCAN_CHK: begin
        cmd_o.find_done = status_i.scan_hit;
        cmd_o.find_hit  = status_i.scan_hit;
        cmd_o.scan_next = !status_i.scan_hit;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- sv/bba_datapath.sv -----
// Datapath of the block bitmap allocator: map memory, pointers, limit and results.
// Depends on bba_pkg; steered by bba_ctrl through ctrl_cmd_t.
module bba_datapath #(
  parameter int unsigned MAP_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bba_pkg::ctrl_cmd_t  cmd_i,
  output bba_pkg::dp_status_t status_o,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_map_sectors_i,
  input  logic [1:0]          req_type_i,
  input  logic [14:0]         block_index_i,
  output logic                done_o,
  output logic                is_free_o,
  output logic                found_o,
  output logic [14:0]         free_index_o,
  output logic                index_error_o
);

  localparam int unsigned WORDS = MAP_BYTES / bba_pkg::WORD_BYTES;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam int unsigned SW    = AW + 1;

  // Map store, one word of eight bytes per entry
  logic [bba_pkg::WORD_BITS-1:0] mem [WORDS];
  logic [bba_pkg::WORD_BITS-1:0] rdata_q;

  logic [3:0]    map_sect_q;
  logic [1:0]    req_q;
  logic [14:0]   blk_q;
  logic [AW-1:0] clr_addr_q;
  logic [SW-1:0] scan_addr_q;

  logic                 done_q, is_free_q, found_q, err_q;
  logic [14:0]          free_idx_q;

  // Map in use, in words, capped by the store and by the index range
  logic [bba_pkg::LIM_W-1:0] lim_sect, lim_words;
  always_comb begin
    lim_sect  = {7'd0, map_sect_q, 6'd0};
    lim_words = lim_sect;
    if (lim_words > bba_pkg::LIM_W'(WORDS)) lim_words = bba_pkg::LIM_W'(WORDS);
    if (lim_words > bba_pkg::LIM_W'(bba_pkg::IDX_WORDS)) begin
      lim_words = bba_pkg::LIM_W'(bba_pkg::IDX_WORDS);
    end
  end

  logic [AW-1:0] blk_word;
  logic          idx_err;
  assign blk_word = AW'(blk_q[14:6]);
  assign idx_err  = (bba_pkg::LIM_W'(blk_q[14:6]) >= lim_words);

  // Lowest byte with a free bit, then lowest free bit in it
  logic       hit;
  logic [2:0] hit_byte, hit_bit;
  logic [7:0] sel_byte;
  always_comb begin
    hit      = 1'b0;
    hit_byte = '0;
    hit_bit  = '0;
    for (int k = bba_pkg::WORD_BYTES - 1; k >= 0; k--) begin
      if (rdata_q[8*k +: 8] != bba_pkg::FULL_BYTE) begin
        hit      = 1'b1;
        hit_byte = 3'(k);
      end
    end
    sel_byte = rdata_q[8*hit_byte +: 8];
    for (int b = 7; b >= 0; b--) begin
      if (!sel_byte[b]) hit_bit = 3'(b);
    end
  end

  logic [31:0] find_idx;
  assign find_idx = (32'(scan_addr_q) << 6) | (32'(hit_byte) << 3) | 32'(hit_bit);

  // Marked word for write-back
  logic [bba_pkg::WORD_BITS-1:0] bit_mask, mark_word;
  logic                          mark_we;
  always_comb begin
    bit_mask  = '0;
    bit_mask[blk_q[5:0]] = 1'b1;
    mark_word = (req_q == bba_pkg::REQ_MARK_USED) ? (rdata_q | bit_mask)
                                                 : (rdata_q & ~bit_mask);
  end
  assign mark_we = cmd_i.op_finish && !idx_err &&
                   (req_q == bba_pkg::REQ_MARK_USED || req_q == bba_pkg::REQ_MARK_FREE);

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem[clr_addr_q] <= '0;
    end else if (mark_we) begin
      mem[blk_word] <= mark_word;
    end
    if (cmd_i.op_read) begin
      rdata_q <= mem[blk_word];
    end else if (cmd_i.scan_read) begin
      rdata_q <= mem[scan_addr_q[AW-1:0]];
    end
  end

  // Config register and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_sect_q  <= bba_pkg::MAP_SECT_RST;
      clr_addr_q  <= '0;
      scan_addr_q <= '0;
    end else begin
      if (cfg_we_i) map_sect_q <= cfg_map_sectors_i;
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + 1'b1;
      if (cmd_i.load) begin
        scan_addr_q <= '0;
      end else if (cmd_i.scan_next) begin
        scan_addr_q <= scan_addr_q + 1'b1;
      end
    end
  end

  // Latched request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      blk_q <= block_index_i;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.op_finish || cmd_i.find_done;
    end
  end

  // Result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.op_finish) begin
      is_free_q  <= !idx_err && (req_q == bba_pkg::REQ_QUERY) && !rdata_q[blk_q[5:0]];
      found_q    <= 1'b0;
      free_idx_q <= '0;
      err_q      <= idx_err;
    end else if (cmd_i.find_done) begin
      is_free_q  <= 1'b0;
      found_q    <= cmd_i.find_hit;
      free_idx_q <= cmd_i.find_hit ? find_idx[14:0] : 15'd0;
      err_q      <= 1'b0;
    end
  end

  assign status_o.clr_last    = (clr_addr_q == AW'(WORDS - 1));
  assign status_o.start_find  = (req_type_i == bba_pkg::REQ_FIND);
  assign status_o.idx_err     = idx_err;
  assign status_o.scan_in_rng = (bba_pkg::LIM_W'(scan_addr_q) < lim_words);
  assign status_o.scan_hit    = hit;

  assign done_o        = done_q;
  assign is_free_o     = is_free_q;
  assign found_o       = found_q;
  assign free_index_o  = free_idx_q;
  assign index_error_o = err_q;

endmodule

// ----- sv/block_bitmap_allocator_core.sv -----
// Top level of the block bitmap allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
// Free-space bitmap, one bit per block (1 = used), held in a memory of
// MAP_BYTES/8 words of 64 bits. After reset a clearing pass zeroes one word a
// cycle until the whole map is clear, with busy high; configuration writes
// are taken throughout. A request is taken when start is high and busy low;
// its single result appears for one cycle with done_o and cannot be held
// off. Query and mark do one memory read, then give the result and any
// write-back; an out-of-range index gives its error result without the read.
// A find walks the map one 64-bit word at a time (memory read, then byte
// check) and stops at the first word with a free block, or after the words
// in use (map_sectors*64, capped at MAP_BYTES/8 and at 512) when nothing is
// free. cfg_ready_o is always high.
module block_bitmap_allocator_core #(
  parameter int unsigned MAP_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [14:0] block_index_i,
  output logic        done_o,
  output logic        is_free_o,
  output logic        found_o,
  output logic [14:0] free_index_o,
  output logic        index_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_map_sectors_i
);

  bba_pkg::ctrl_cmd_t  cmd;
  bba_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  bba_datapath #(
    .MAP_BYTES (MAP_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_map_sectors_i (cfg_map_sectors_i),
    .req_type_i        (req_type_i),
    .block_index_i     (block_index_i),
    .done_o            (done_o),
    .is_free_o         (is_free_o),
    .found_o           (found_o),
    .free_index_o      (free_index_o),
    .index_error_o     (index_error_o)
  );

endmodule

// ----- sv/bba_checker.sv -----
// Port-level checks for the block bitmap allocator, bound to the top level.
// Depends only on the ports of block_bitmap_allocator_core.
module bba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        is_free_o,
  input logic        found_o,
  input logic [14:0] free_index_o,
  input logic        index_error_o
);

  // An accepted request is always followed by busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request transfer not followed by busy");

  // A result is always preceded by busy
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without preceding work");

  // A result reports at most one of its flags
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $countones({is_free_o, found_o, index_error_o}) <= 1)
    else $error("conflicting result flags");

  // A failed or non-find result carries no block number
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> free_index_o == 15'd0)
    else $error("free_index set without found");

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .is_free_o     (is_free_o),
  .found_o       (found_o),
  .free_index_o  (free_index_o),
  .index_error_o (index_error_o)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for block_bitmap_allocator_core: a directed table then random
// request traffic, each result checked against its typed row or a bit-accurate free-map predictor.
// Depends on bba_pkg and the RTL of the allocator; reads no files.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SECTOR_SIZE = 512;
  localparam int unsigned MAP_SIZE    = 4096;
  localparam int unsigned DIR_ROWS    = 25;

  // One result, field for field as on the result ports
  typedef struct packed {
    logic        is_free;
    logic        found;
    logic [14:0] free_index;
    logic        index_error;
  } alloc_res_t;

  // Directed row; typed rows carry their expected result, others use the predictor
  typedef struct packed {
    bba_pkg::req_e req;
    logic [14:0]   idx;
    logic          typed;
    alloc_res_t    res;
  } dir_row_t;

  localparam alloc_res_t RES_NONE = '0;
  localparam alloc_res_t RES_ERR  = '{1'b0, 1'b0, 15'd0, 1'b1};
  localparam alloc_res_t RES_FREE = '{1'b1, 1'b0, 15'd0, 1'b0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [14:0] block_index_i = '0;
  logic        done_o;
  logic        is_free_o;
  logic        found_o;
  logic [14:0] free_index_o;
  logic        index_error_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_map_sectors_i = '0;

  // Predictor state: shadow of the used-block map and of map_sectors
  logic [7:0]  shadow_map [MAP_SIZE];
  logic [3:0]  sect_cfg;

  alloc_res_t  pending_res [$];
  logic        typed_pending = 1'b0;
  alloc_res_t  typed_res = '0;
  int unsigned fail_cnt = 0;

  // Reset map: all free, then claims, a full byte, a release and the edges of the map
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{bba_pkg::REQ_QUERY,     15'd0,     1'b1, RES_FREE},
    '{bba_pkg::REQ_QUERY,     15'd28671, 1'b1, RES_FREE},
    '{bba_pkg::REQ_QUERY,     15'd28672, 1'b1, RES_ERR},
    '{bba_pkg::REQ_QUERY,     15'd32767, 1'b1, RES_ERR},
    '{bba_pkg::REQ_FIND,      15'd32767, 1'b1, '{1'b0, 1'b1, 15'd0, 1'b0}},
    '{bba_pkg::REQ_MARK_USED, 15'd0,     1'b1, RES_NONE},
    '{bba_pkg::REQ_MARK_USED, 15'd32767, 1'b1, RES_ERR},
    '{bba_pkg::REQ_MARK_FREE, 15'd28672, 1'b1, RES_ERR},
    '{bba_pkg::REQ_QUERY,     15'd0,     1'b1, RES_NONE},
    '{bba_pkg::REQ_FIND,      15'd0,     1'b0, RES_NONE},
    '{bba_pkg::REQ_MARK_USED, 15'd1,     1'b0, RES_NONE},
    '{bba_pkg::REQ_MARK_USED, 15'd2,     1'b0, RES_NONE},
    '{bba_pkg::REQ_MARK_USED, 15'd3,     1'b0, RES_NONE},
    '{bba_pkg::REQ_MARK_USED, 15'd4,     1'b0, RES_NONE},
    '{bba_pkg::REQ_MARK_USED, 15'd5,     1'b0, RES_NONE},
    '{bba_pkg::REQ_MARK_USED, 15'd6,     1'b0, RES_NONE},
    '{bba_pkg::REQ_FIND,      15'd0,     1'b0, RES_NONE},
    '{bba_pkg::REQ_MARK_USED, 15'd7,     1'b0, RES_NONE},
    '{bba_pkg::REQ_FIND,      15'd0,     1'b0, RES_NONE},
    '{bba_pkg::REQ_MARK_FREE, 15'd3,     1'b0, RES_NONE},
    '{bba_pkg::REQ_FIND,      15'd0,     1'b0, RES_NONE},
    '{bba_pkg::REQ_QUERY,     15'd3,     1'b0, RES_NONE},
    '{bba_pkg::REQ_MARK_USED, 15'd28671, 1'b0, RES_NONE},
    '{bba_pkg::REQ_QUERY,     15'd28671, 1'b0, RES_NONE},
    '{bba_pkg::REQ_MARK_FREE, 15'd28671, 1'b0, RES_NONE}
  };

  block_bitmap_allocator_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .block_index_i     (block_index_i),
    .done_o            (done_o),
    .is_free_o         (is_free_o),
    .found_o           (found_o),
    .free_index_o      (free_index_o),
    .index_error_o     (index_error_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_map_sectors_i (cfg_map_sectors_i)
  );

  always #5 clk_i = ~clk_i;

  // Bytes of map in use, capped at the store size
  function automatic int unsigned bytes_in_use();
    int unsigned n;
    n = sect_cfg * SECTOR_SIZE;
    if (n > MAP_SIZE) n = MAP_SIZE;
    return n;
  endfunction

  // Lowest free block: skip full bytes, then the lowest clear bit
  function automatic alloc_res_t lowest_free();
    alloc_res_t res;
    int unsigned lim;
    res = '0;
    lim = bytes_in_use();
    for (int unsigned i = 0; i < lim; i++) begin
      if (shadow_map[i] != 8'hFF) begin
        res.found = 1'b1;
        for (int j = 7; j >= 0; j--)
          if (!shadow_map[i][j]) res.free_index = 15'(i * 8 + j);
        return res;
      end
    end
    return res;
  endfunction

  // Expected result of one request; marks update the shadow map
  function automatic alloc_res_t predict_alloc(bba_pkg::req_e r, logic [14:0] b);
    alloc_res_t res;
    int unsigned byte_no;
    res = '0;
    byte_no = b >> 3;
    if (r == bba_pkg::REQ_FIND) begin
      res = lowest_free();
    end else if (byte_no >= bytes_in_use()) begin
      res.index_error = 1'b1;
    end else begin
      case (r)
        bba_pkg::REQ_QUERY:     res.is_free = ~shadow_map[byte_no][b[2:0]];
        bba_pkg::REQ_MARK_USED: shadow_map[byte_no][b[2:0]] = 1'b1;
        default:                shadow_map[byte_no][b[2:0]] = 1'b0;
      endcase
    end
    return res;
  endfunction

  // Monitor: check results, track register writes, predict accepted requests
  always @(posedge clk_i) begin
    alloc_res_t got;
    alloc_res_t want;
    alloc_res_t pred;
    if (rst_ni) begin
      if (done_o) begin
        got = '{is_free_o, found_o, free_index_o, index_error_o};
        if (pending_res.size() == 0) begin
          $error("unexpected result: %p", got);
          fail_cnt++;
        end else begin
          want = pending_res.pop_front();
          if (got.is_free !== want.is_free) begin
            $error("is_free: expected %0d, got %0d", want.is_free, got.is_free);
            fail_cnt++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_cnt++;
          end
          if (got.free_index !== want.free_index) begin
            $error("free_index: expected %0d, got %0d", want.free_index, got.free_index);
            fail_cnt++;
          end
          if (got.index_error !== want.index_error) begin
            $error("index_error: expected %0d, got %0d", want.index_error,
                   got.index_error);
            fail_cnt++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) sect_cfg = cfg_map_sectors_i;
      if (start && !busy) begin
        pred = predict_alloc(bba_pkg::req_e'(req_type_i), block_index_i);
        pending_res.push_back(typed_pending ? typed_res : pred);
      end
    end
  end

  // One request transfer; entered and left at a falling edge
  task automatic send_req(input bba_pkg::req_e r, input logic [14:0] b,
                          input int unsigned idle_pct,
                          input logic typed = 1'b0, input alloc_res_t res = '0);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start         <= 1'b1;
    req_type_i    <= r;
    block_index_i <= b;
    typed_pending = typed;
    typed_res     = res;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off until every result is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_res.size() != 0 || busy);
  endtask

  task automatic write_sectors(input logic [3:0] v);
    cfg_valid_i       <= 1'b1;
    cfg_map_sectors_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly inside the map in use, sometimes anywhere in the 15-bit range
  function automatic logic [14:0] rand_index();
    int unsigned blocks;
    blocks = bytes_in_use() * 8;
    if (blocks > 0 && $urandom_range(99) < 80) return 15'($urandom_range(blocks - 1, 0));
    return 15'($urandom_range(32767, 0));
  endfunction

  // Random traffic, weighted towards find-then-claim allocation
  task automatic rand_item(input int unsigned idle_pct);
    int unsigned pick;
    alloc_res_t nxt;
    pick = $urandom_range(99);
    if (pick < 35) begin
      nxt = lowest_free();
      send_req(bba_pkg::REQ_FIND, 15'($urandom), idle_pct);
      // now and then the claim is abandoned
      if ($urandom_range(9) != 0)
        send_req(bba_pkg::REQ_MARK_USED, nxt.found ? nxt.free_index : rand_index(),
                 idle_pct);
    end else if (pick < 55) begin
      send_req(bba_pkg::REQ_QUERY, rand_index(), idle_pct);
    end else if (pick < 75) begin
      send_req(bba_pkg::REQ_MARK_FREE, rand_index(), idle_pct);
    end else if (pick < 90) begin
      send_req(bba_pkg::REQ_MARK_USED, rand_index(), idle_pct);
    end else begin
      send_req(bba_pkg::REQ_FIND, 15'($urandom), idle_pct);
    end
  endtask

  // Stimulus
  initial begin
    logic [3:0]  phase_sect [5];
    int unsigned phase_idle [5];
    int unsigned phase_len  [5];
    foreach (shadow_map[i]) shadow_map[i] = '0;
    sect_cfg = bba_pkg::MAP_SECT_RST;
    phase_sect = '{4'd1, 4'd15, 4'd8, 4'($urandom_range(14, 2)), 4'd1};
    phase_idle = '{76, 0, 35, 0, 35};
    phase_len  = '{80, 70, 70, 50, 40};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table on the reset-value map size
    for (int i = 0; i < DIR_ROWS; i++)
      send_req(dir_tab[i].req, dir_tab[i].idx, 0, dir_tab[i].typed, dir_tab[i].res);
    drain();

    // empty map: every index out of range, nothing ever found
    write_sectors(4'd0);
    repeat (12) rand_item(0);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_sectors(phase_sect[p]);
      for (int n = 0; n < phase_len[p]; n++) begin
        rand_item(phase_idle[p]);
        // pause the sender now and then until all results are back
        if (p == 3 && n % 20 == 19) drain();
      end
      drain();
    end

    repeat (1100) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
